### rtl/core/stc_pkg.sv
// Shared types and constants for the s-expression token classifier.
`default_nettype none

package stc_pkg;

    // Token kinds as they appear on the result channel
    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_STRING = 3'd1,
        KIND_IDENT  = 3'd2,
        KIND_OPEN   = 3'd3,
        KIND_CLOSE  = 3'd4,
        KIND_ERROR  = 3'd5
    } kind_t;

    // One token result
    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [7:0]  length;
    } result_t;

    // One queue entry: the one or two results caused by one character
    typedef struct packed {
        logic    two;    // res1 is also valid
        logic    eos;    // character ended the source
        result_t res0;
        result_t res1;
    } entry_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Character codes
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

`default_nettype wire

### rtl/core/stc_front.sv
// Front end: per-character word tracking and token classification.
`default_nettype none

module stc_front #(
    parameter int MAX_TOKEN_LENGTH = 255,
    parameter int POSITION_BITS    = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [7:0]     char_code,
    input  wire logic           end_of_source,
    input  wire logic           take,
    output stc_pkg::entry_t     entry,
    output logic                push
);
    import stc_pkg::*;

    localparam int LEN_BITS = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int LEN_EXT  = (LEN_BITS > 8) ? LEN_BITS : 8;
    localparam int POS_EXT  = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_TOKEN_LENGTH);

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_head(input logic [7:0] c);
        is_ident_head = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                        c == 8'h5F || c == 8'h2B || c == CH_MINUS || c == 8'h2A ||
                        c == 8'h2F || c == 8'h3E || c == 8'h3C || c == 8'h3D ||
                        c == 8'h21 || c == 8'h3F;
    endfunction

    // Word state
    logic [LEN_BITS-1:0]      len_reg, len_next;
    logic [15:0]              start_reg, start_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic np_reg, np_next, ds_reg, ds_next, ip_reg, ip_next;
    logic oq_reg, oq_next, cq_reg, cq_next, err_reg, err_next;

    logic is_sp, is_par, is_dig, is_head, is_quote, word_char;
    logic [POS_EXT-1:0] pos_wide;
    logic [15:0]        pos16;

    // Word state after adding this character
    logic [LEN_BITS-1:0] a_len;
    logic [15:0]         a_start;
    logic a_np, a_ds, a_ip, a_oq, a_cq;

    // Word being flushed
    logic [LEN_BITS-1:0] f_len;
    logic [15:0]         f_start;
    logic f_np, f_ds, f_ip, f_oq, f_cq, f_has, f_err, flush;
    kind_t               f_kind;
    logic [LEN_EXT-1:0]  len_wide;
    logic [7:0]          len_out;
    result_t             word_res, paren_res;

    // Character decode
    always_comb begin
        is_sp     = (char_code == CH_SPACE) || (char_code >= 8'd9 && char_code <= 8'd13);
        is_par    = (char_code == CH_OPEN) || (char_code == CH_CLOSE);
        is_dig    = is_digit(char_code);
        is_head   = is_ident_head(char_code);
        is_quote  = (char_code == CH_QUOTE);
        word_char = !is_sp && !is_par;
        pos_wide  = POS_EXT'(pos_reg);
        pos16     = pos_wide[15:0];
    end

    // Append the character to the pending word
    always_comb begin
        if (len_reg == '0) begin
            a_start = pos16;
            a_np    = is_dig || (char_code == CH_MINUS);
            a_ds    = is_dig;
            a_ip    = is_head;
            a_oq    = is_quote;
        end else begin
            a_start = start_reg;
            a_np    = np_reg && is_dig;
            a_ds    = ds_reg || is_dig;
            a_ip    = ip_reg && (is_dig || is_head);
            a_oq    = oq_reg;
        end
        a_cq  = is_quote;
        a_len = (len_reg < LEN_MAX) ? LEN_BITS'(len_reg + 1'b1) : len_reg;
    end

    // Classify the word that a flush would report
    always_comb begin
        if (word_char) begin
            f_len = a_len; f_start = a_start; f_np = a_np; f_ds = a_ds;
            f_ip  = a_ip;  f_oq = a_oq;       f_cq = a_cq;
        end else begin
            f_len = len_reg; f_start = start_reg; f_np = np_reg; f_ds = ds_reg;
            f_ip  = ip_reg;  f_oq = oq_reg;       f_cq = cq_reg;
        end
        f_has = (f_len != '0);
        priority if (f_np && f_ds) begin
            f_kind = KIND_NUMBER;
        end else if ((f_len >= LEN_BITS'(2)) && f_oq && f_cq) begin
            f_kind = KIND_STRING;
        end else if (f_ip) begin
            f_kind = KIND_IDENT;
        end else begin
            f_kind = KIND_ERROR;
        end
        f_err    = (f_kind == KIND_ERROR);
        len_wide = LEN_EXT'(f_len);
        len_out  = (len_wide > LEN_EXT'(255)) ? 8'hFF : len_wide[7:0];
        word_res = '{kind: f_kind, start: f_start, length: len_out};
        paren_res = '{kind: kind_t'((char_code == CH_OPEN) ? KIND_OPEN : KIND_CLOSE),
                      start: pos16, length: 8'd1};
        flush = !err_reg && (!word_char || end_of_source);
    end

    // Results caused by this character
    always_comb begin
        entry.eos  = end_of_source;
        entry.two  = 1'b0;
        entry.res0 = word_res;
        entry.res1 = paren_res;
        push       = 1'b0;
        if (!err_reg) begin
            if (is_sp) begin
                push = f_has;
            end else if (is_par) begin
                push = 1'b1;
                if (!f_has) begin
                    entry.res0 = paren_res;
                end else if (!f_err) begin
                    entry.two = 1'b1;
                end
            end else begin
                push = end_of_source;
            end
        end
    end

    // Next state
    always_comb begin
        len_next = len_reg; start_next = start_reg; np_next = np_reg; ds_next = ds_reg;
        ip_next  = ip_reg;  oq_next = oq_reg;       cq_next = cq_reg;
        err_next = err_reg;
        pos_next = POSITION_BITS'(pos_reg + 1'b1);
        if (!err_reg && word_char) begin
            len_next = a_len; start_next = a_start; np_next = a_np; ds_next = a_ds;
            ip_next  = a_ip;  oq_next = a_oq;       cq_next = a_cq;
        end
        if (flush) begin
            len_next = '0; start_next = '0; np_next = 1'b1; ds_next = 1'b0;
            ip_next  = 1'b1; oq_next = 1'b0; cq_next = 1'b0;
            err_next = err_reg || (f_has && f_err);
        end
        if (end_of_source) begin
            len_next = '0; start_next = '0; np_next = 1'b1; ds_next = 1'b0;
            ip_next  = 1'b1; oq_next = 1'b0; cq_next = 1'b0;
            err_next = 1'b0;
            pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            np_reg    <= 1'b1;
            ds_reg    <= 1'b0;
            ip_reg    <= 1'b1;
            oq_reg    <= 1'b0;
            cq_reg    <= 1'b0;
            err_reg   <= 1'b0;
        end else if (take) begin
            len_reg   <= len_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            np_reg    <= np_next;
            ds_reg    <= ds_next;
            ip_reg    <= ip_next;
            oq_reg    <= oq_next;
            cq_reg    <= cq_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/stc_queue.sv
// Short FIFO of classified entries between front and back.
`default_nettype none

module stc_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire stc_pkg::entry_t       entry_in,
    input  wire logic                  pop,
    output stc_pkg::entry_t            entry_out,
    output stc_pkg::queue_status_t     status
);
    import stc_pkg::*;

    entry_t               mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    // Pointer and fill tracking
    always_comb begin
        status.not_empty = (count_reg != '0);
        status.full      = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
        do_push     = push && !status.full;
        do_pop      = pop && status.not_empty;
        wr_ptr_next = do_push ? QPTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? QPTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = (QPTR_BITS + 1)'(count_reg + 1'b1);
            2'b01:   count_next = (QPTR_BITS + 1)'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
        entry_out = mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

`default_nettype wire

### rtl/core/stc_back.sv
// Back end: splits queue entries into single results behind an output register.
`default_nettype none

module stc_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire stc_pkg::entry_t       head,
    input  wire stc_pkg::queue_status_t status,
    output logic                       pop,
    output stc_pkg::result_t           res,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic                       res_last,
    output logic                       res_done
);
    import stc_pkg::*;

    logic    sub_reg, sub_next;
    logic    valid_reg, valid_next, last_reg, last_next, done_reg, done_next;
    result_t res_reg, res_next;
    logic    load, entry_end;

    // Pick the next result out of the head entry
    always_comb begin
        load       = !valid_reg || res_ready;
        entry_end  = !head.two || sub_reg;
        sub_next   = sub_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = status.not_empty;
            if (status.not_empty) begin
                res_next  = sub_reg ? head.res1 : head.res0;
                last_next = entry_end;
                done_next = entry_end && head.eos;
                pop       = entry_end;
                sub_next  = !entry_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign res       = res_reg;
    assign res_valid = valid_reg;
    assign res_last  = last_reg;
    assign res_done  = done_reg;

endmodule

`default_nettype wire

### rtl/core/sexpr_token_classifier_unit.sv
// Top level of the s-expression token classifier.
// Takes one source character per cycle while the queue is not full, and reports
// each word, once ended by whitespace, a parenthesis or the end-of-source mark,
// as a token with its kind, start offset and length; parentheses are tokens of
// their own. Input acceptance runs at one character per cycle unless the queue
// is full; a character that yields two tokens (a word closed by a parenthesis)
// gives two output results, and a four-entry queue between the classifier and
// the output stage absorbs these bursts, so the sustained rate is one character
// per cycle as long as tokens average no more than one per cycle. A token goes
// through the queue and the output register before it appears. After an unknown
// token, no results appear until the character marked as end of source.
`default_nettype none

module sexpr_token_classifier_unit #(
    parameter int MAX_TOKEN_LENGTH = 255,
    parameter int POSITION_BITS    = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // end_of_source
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [2:0] token_kind, [18:3] token_start,
                                        // [26:19] token_length, [31:27] zero
    output logic             m_tlast,   // run_last
    output logic             m_tuser    // source_done
);
    import stc_pkg::*;

    entry_t        front_entry, head_entry;
    queue_status_t q_status;
    logic          take, front_push, pop;
    result_t       out_res;

    assign s_tready = !q_status.full;
    assign take     = s_tvalid && s_tready;

    stc_front #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
        .POSITION_BITS    (POSITION_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .char_code     (s_tdata),
        .end_of_source (s_tlast),
        .take          (take),
        .entry         (front_entry),
        .push          (front_push)
    );

    stc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take && front_push),
        .entry_in  (front_entry),
        .pop       (pop),
        .entry_out (head_entry),
        .status    (q_status)
    );

    stc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head_entry),
        .status    (q_status),
        .pop       (pop),
        .res       (out_res),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_last  (m_tlast),
        .res_done  (m_tuser)
    );

    assign m_tdata = {5'b0, out_res.length, out_res.start, out_res.kind};

endmodule

`default_nettype wire

### rtl/core/stc_checker.sv
// Port-level checks for the token classifier, bound to the top level.
`default_nettype none

module stc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);
    import stc_pkg::*;

    // Output register is empty and input is open right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input blocked right after reset");

    // A stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // End of source only on the last item of a character
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("source_done without run_last");

    // Kind is a defined code
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= KIND_ERROR)
        else $error("undefined token kind");

    // Parentheses are one character long
    a_paren_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == KIND_OPEN || m_tdata[2:0] == KIND_CLOSE)
        |-> m_tdata[26:19] == 8'd1)
        else $error("parenthesis token with length other than one");

endmodule

bind sexpr_token_classifier_unit stc_checker u_stc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/sv/tb_sexpr_token_classifier_unit.sv
// Self-checking testbench for the s-expression token classifier unit.
`default_nettype none

module tb_sexpr_token_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import stc_pkg::*;

    // One expected token as it should leave the result channel
    typedef struct {
        kind_t      kind;
        bit [15:0]  start;
        bit [7:0]   length;
        bit         run_last;
        bit         source_done;
    } exp_token_t;

    // Tracks the tokenizer state and holds the tokens still owed by the block
    class token_scoreboard;
        exp_token_t tokens_owed[$];
        exp_token_t step_q[$];
        int         errors;
        bit [7:0]   word_len;
        bit [15:0]  word_pos;
        bit [15:0]  char_pos;
        bit         num_ok;
        bit         digit_seen;
        bit         ident_ok;
        bit         open_quote;
        bit         close_quote;
        bit         err_hold;

        function new();
            clear_word();
            char_pos = '0;
            err_hold = 1'b0;
            errors   = 0;
        endfunction

        function void clear_word();
            word_len    = '0;
            word_pos    = '0;
            num_ok      = 1'b1;
            digit_seen  = 1'b0;
            ident_ok    = 1'b1;
            open_quote  = 1'b0;
            close_quote = 1'b0;
        endfunction

        function bit is_space(bit [7:0] ch);
            return ch == CH_SPACE || (ch >= 8'd9 && ch <= 8'd13);
        endfunction

        function bit is_digit(bit [7:0] ch);
            return ch >= 8'h30 && ch <= 8'h39;
        endfunction

        // letters and _ + - * / > < = ! ?
        function bit is_ident_head(bit [7:0] ch);
            return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
                   ch == 8'h5F || ch == 8'h2B || ch == CH_MINUS || ch == 8'h2A ||
                   ch == 8'h2F || ch == 8'h3E || ch == 8'h3C || ch == 8'h3D ||
                   ch == 8'h21 || ch == 8'h3F;
        endfunction

        function void add_token(kind_t k, bit [15:0] s, bit [7:0] l);
            exp_token_t t;
            t.kind        = k;
            t.start       = s;
            t.length      = l;
            t.run_last    = 1'b0;
            t.source_done = 1'b0;
            step_q = {step_q, t};
        endfunction

        function void add_char(bit [7:0] ch, bit [15:0] pos);
            bit dig;
            dig = is_digit(ch);
            if (word_len == 0) begin
                word_pos   = pos;
                num_ok     = dig || ch == CH_MINUS;
                digit_seen = dig;
                ident_ok   = is_ident_head(ch);
                open_quote = (ch == CH_QUOTE);
            end else begin
                if (dig) digit_seen = 1'b1;
                else num_ok = 1'b0;
                if (!(dig || is_ident_head(ch))) ident_ok = 1'b0;
            end
            close_quote = (ch == CH_QUOTE);
            // length saturates, classification keeps going
            if (word_len != 8'd255) word_len++;
        endfunction

        // Classify the pending word in priority order
        function void flush_word();
            kind_t k;
            if (word_len == 0) return;
            if (num_ok && digit_seen) k = KIND_NUMBER;
            else if (word_len >= 2 && open_quote && close_quote) k = KIND_STRING;
            else if (ident_ok) k = KIND_IDENT;
            else k = KIND_ERROR;
            add_token(k, word_pos, word_len);
            if (k == KIND_ERROR) err_hold = 1'b1;
            clear_word();
        endfunction

        // Accepted input item: work out the tokens it causes
        function void note_char(bit [7:0] ch, bit eos);
            bit [15:0] pos;
            pos = char_pos;
            step_q.delete();
            if (!err_hold) begin
                if (is_space(ch)) begin
                    flush_word();
                end else if (ch == CH_OPEN || ch == CH_CLOSE) begin
                    // a bad word in front swallows the paren
                    flush_word();
                    if (!err_hold)
                        add_token(kind_t'(ch == CH_OPEN ? KIND_OPEN : KIND_CLOSE),
                                  pos, 8'd1);
                end else begin
                    add_char(ch, pos);
                    if (eos) flush_word();
                end
            end
            char_pos = pos + 16'd1;
            if (step_q.size() > 0) begin
                step_q[step_q.size() - 1].run_last    = 1'b1;
                step_q[step_q.size() - 1].source_done = eos;
            end
            tokens_owed = {tokens_owed, step_q};
            // end of source starts everything over
            if (eos) begin
                clear_word();
                char_pos = '0;
                err_hold = 1'b0;
            end
        endfunction

        function void report(string what, logic [31:0] e, logic [31:0] a);
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, e, a);
        endfunction

        // Accepted result item: compare with the oldest owed token
        function void check_token(logic [31:0] d, logic last, logic done);
            exp_token_t e;
            bit bad;
            if (tokens_owed.size() == 0) begin
                $display("%0t: unexpected token, expected none, got data %h", $time, d);
                errors++;
                return;
            end
            e   = tokens_owed.pop_front();
            bad = 1'b0;
            if (d[2:0] !== e.kind) begin
                report("token_kind", 32'(e.kind), 32'(d[2:0]));
                bad = 1'b1;
            end
            if (d[18:3] !== e.start) begin
                report("token_start", 32'(e.start), 32'(d[18:3]));
                bad = 1'b1;
            end
            if (d[26:19] !== e.length) begin
                report("token_length", 32'(e.length), 32'(d[26:19]));
                bad = 1'b1;
            end
            if (d[31:27] !== 5'd0) begin
                report("tdata padding", 32'd0, 32'(d[31:27]));
                bad = 1'b1;
            end
            if (last !== e.run_last) begin
                report("run_last", 32'(e.run_last), 32'(last));
                bad = 1'b1;
            end
            if (done !== e.source_done) begin
                report("source_done", 32'(e.source_done), 32'(done));
                bad = 1'b1;
            end
            if (bad) errors++;
        endfunction
    endclass

    // _ + - * / > < = ! ?
    localparam bit [7:0] IDENT_SYM [10] = '{8'h5F, 8'h2B, 8'h2D, 8'h2A, 8'h2F,
                                            8'h3E, 8'h3C, 8'h3D, 8'h21, 8'h3F};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    token_scoreboard sb;
    bit [7:0]        src_buf[$];
    int              items_sent = 0;
    int              rx_hold    = 0;
    bit              idle_on    = 1'b1;
    bit              src_gappy  = 1'b1;

    sexpr_token_classifier_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // Result side: ready stretches broken by random stalls
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (!idle_on || $urandom_range(0, 99) < 60) begin
            m_tready <= 1'b1;
            rx_hold  <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b0;
            rx_hold  <= pick_gap() - 1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_token(m_tdata, m_tlast, m_tuser);
    end

    // Append one byte to the source buffer
    function automatic void put_byte(bit [7:0] b);
        src_buf = {src_buf, b};
    endfunction

    task automatic send_char(bit [7:0] ch, bit eos);
        int gap;
        gap = 0;
        if (idle_on && src_gappy && $urandom_range(0, 9) < 3) gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_char(ch, eos);
        items_sent++;
    endtask

    // Send the buffered characters, flagging the last one if the source ends
    task automatic send_buf(bit end_source);
        foreach (src_buf[i])
            send_char(src_buf[i], end_source && i == src_buf.size() - 1);
        src_buf.delete();
    endtask

    // Hold off input until every owed token has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.tokens_owed.size() != 0) @(posedge aclk);
    endtask

    function automatic bit [7:0] word_char(bit head);
        int r;
        r = $urandom_range(0, head ? 84 : 99);
        if (r < 40) return 8'(8'h61 + $urandom_range(0, 25));
        else if (r < 70) return 8'(8'h41 + $urandom_range(0, 25));
        else if (r < 85) return IDENT_SYM[$urandom_range(0, 9)];
        else return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    // a byte from 33 to 255 that is not a paren, so never whitespace
    function automatic bit [7:0] plain_byte();
        bit [7:0] b;
        do b = 8'($urandom_range(33, 255)); while (b == CH_OPEN || b == CH_CLOSE);
        return b;
    endfunction

    function automatic bit [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r < 5) ? 8'(9 + r) : CH_SPACE;
    endfunction

    // Append one token and maybe a separator; clean leaves out bad words
    function automatic void push_token(bit clean);
        int pick;
        int n;
        pick = clean ? $urandom_range(0, 79) : $urandom_range(0, 99);
        if (pick < 25) begin
            n = $urandom_range(1, 8);
            put_byte(word_char(1));
            repeat (n - 1) put_byte(word_char(0));
        end else if (pick < 45) begin
            if ($urandom_range(0, 3) == 0) put_byte(CH_MINUS);
            n = $urandom_range(1, 6);
            repeat (n) put_byte(8'(8'h30 + $urandom_range(0, 9)));
        end else if (pick < 60) begin
            put_byte(CH_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n) put_byte(plain_byte());
            put_byte(CH_QUOTE);
        end else if (pick < 80) begin
            put_byte($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
        end else if (pick < 88) begin
            // malformed word: digit then letter, or a lone quote
            if ($urandom_range(0, 2) == 0) begin
                put_byte(CH_QUOTE);
            end else begin
                put_byte(8'(8'h30 + $urandom_range(0, 9)));
                put_byte(8'(8'h61 + $urandom_range(0, 25)));
            end
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) < 6) put_byte(blank_byte());
    endfunction

    initial begin
        int rand_goal;
        int run_goal;
        bit paused;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: paren, number, string, identifier closed by paren, high byte at end
        send_char(CH_OPEN, 0);
        send_char(CH_MINUS, 0);
        send_char(8'h30, 0);
        send_char(8'h39, 0);
        send_char(CH_SPACE, 0);
        send_char(CH_QUOTE, 0);
        send_char(8'h7A, 0);
        send_char(CH_QUOTE, 0);
        send_char(8'h09, 0);
        send_char(8'h41, 0);
        send_char(8'h7A, 0);
        send_char(8'h5F, 0);
        send_char(8'h3F, 0);
        send_char(8'h39, 0);
        send_char(CH_CLOSE, 0);
        send_char(8'h0A, 0);
        send_char(8'hFF, 1);
        // bad word before paren, then error hold ending quietly
        send_char(8'h31, 0);
        send_char(8'h61, 0);
        send_char(CH_OPEN, 0);
        send_char(8'h00, 0);
        send_char(CH_SPACE, 1);
        // whitespace-only source, quiet end
        send_char(8'h0B, 0);
        send_char(8'h0C, 0);
        send_char(8'h0D, 1);
        drain();

        // Long word: length saturates, the paren still follows
        put_byte(word_char(1));
        repeat (269) put_byte(word_char(0));
        put_byte(CH_CLOSE);
        send_buf(1);

        // Random sources, mostly well-formed
        rand_goal = 800;
        paused    = 1'b0;
        while (items_sent < rand_goal) begin
            src_gappy = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 14) == 0) begin
                repeat ($urandom_range(1, 3)) put_byte(blank_byte());
            end else begin
                repeat ($urandom_range(1, 12)) push_token(0);
            end
            send_buf(1);
            if (!paused && items_sent > rand_goal - 250) begin
                drain();
                paused = 1'b1;
            end
        end

        // One clean source sent back to back with the result side ready once any pending stall runs out
        idle_on   = 1'b0;
        src_gappy = 1'b0;
        run_goal  = 950;
        while (items_sent < run_goal) begin
            push_token(1);
            send_buf(0);
        end
        send_char(CH_CLOSE, 1);
        idle_on = 1'b1;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.tokens_owed.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
